// ----- src/edd_pkg.sv -----
// Shared types, register codes and arithmetic helpers for the error diffusion dither.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package edd_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_WIDTH_BITS = 11;
  localparam int CFG_HEIGHT_BITS = 16;
  localparam int ROW_BITS = 16;
  localparam logic [PIXEL_BITS-1:0] WHITE_THRESHOLD = 8'd127;
  localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = 8'd255;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } edd_reg_t;

  typedef struct packed {
    logic first_col;
    logic last_col;
    logic frame_end;
    logic has_upper;
  } edd_ctl_t;

  // Weighted error term n*e/16, rounded to nearest with ties away from zero.
  function automatic logic signed [7:0] weighted(input logic [2:0] n,
                                                 input logic signed [7:0] e);
    logic signed [11:0] x;
    logic [11:0] mag;
    logic [11:0] q;
    x = $signed({1'b0, n}) * e;
    mag = x[11] ? 12'(-x) : 12'(x);
    q = (mag + 12'd8) >> 4;
    weighted = x[11] ? $signed(-q[7:0]) : $signed(q[7:0]);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] add_clamp(input logic [PIXEL_BITS-1:0] p,
                                                      input logic signed [7:0] t);
    logic signed [9:0] s;
    s = $signed({2'b00, p}) + $signed({{2{t[7]}}, t});
    if (s < 0) begin
      add_clamp = '0;
    end else if (s > $signed({2'b00, PIXEL_MAX})) begin
      add_clamp = PIXEL_MAX;
    end else begin
      add_clamp = s[7:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/edd_front.sv -----
// Front end: configuration registers, column and row counters, request classification.
// Depends on edd_pkg; feeds edd_queue.
`timescale 1ns / 1ps
`default_nettype none
module edd_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  input  wire logic [0:0]                        cfg_index,
  input  wire logic [edd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [edd_pkg::PIXEL_BITS-1:0]    pixel_in,
  input  wire logic                              q_full,
  output logic                                   push,
  output logic [edd_pkg::PIXEL_BITS-1:0]         pixel,
  output logic [AW-1:0]                          col,
  output logic [AW-1:0]                          rd_addr,
  output edd_pkg::edd_ctl_t                      ctl
);
  import edd_pkg::*;

  localparam int CW = (AW + 1 > CFG_WIDTH_BITS) ? AW + 1 : CFG_WIDTH_BITS;
  localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam logic [CW-1:0] MAXC = CW'(MAX_WIDTH);

  logic [AW-1:0] width_last, width_last_next;
  logic [ROW_BITS-1:0] height_last, height_last_next;
  logic [AW-1:0] column_count, column_count_next;
  logic [ROW_BITS-1:0] row_count, row_count_next;
  logic [CW-1:0] wreq;
  logic last_col, last_row;

  always_comb begin
    wreq = CW'(cfg_data[CFG_WIDTH_BITS-1:0]);
    width_last_next = width_last;
    height_last_next = height_last;
    if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (wreq == '0) begin
            width_last_next = '0;
          end else if (wreq > MAXC) begin
            width_last_next = AW'(MAX_WIDTH - 1);
          end else begin
            width_last_next = AW'(wreq - CW'(1));
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_data[CFG_HEIGHT_BITS-1:0] == '0) begin
            height_last_next = '0;
          end else begin
            height_last_next = cfg_data[CFG_HEIGHT_BITS-1:0] - ROW_BITS'(1);
          end
        end
        default: begin
          width_last_next = width_last;
        end
      endcase
    end
  end

  always_comb begin
    last_col = (column_count >= width_last);
    last_row = (row_count >= height_last);
    col = last_col ? width_last : column_count;
    rd_addr = col + AW'(1);
    pixel = pixel_in;
    ctl.first_col = (col == '0);
    ctl.last_col = last_col;
    ctl.frame_end = last_col && last_row;
    ctl.has_upper = (row_count != '0);
    in_stall = q_full;
    push = in_valid && !q_full;
    column_count_next = column_count;
    row_count_next = row_count;
    if (push) begin
      if (last_col) begin
        column_count_next = '0;
        row_count_next = last_row ? '0 : row_count + ROW_BITS'(1);
      end else begin
        column_count_next = col + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last <= AW'(RST_W - 1);
      height_last <= '0;
      column_count <= '0;
      row_count <= '0;
    end else begin
      width_last <= width_last_next;
      height_last <= height_last_next;
      column_count <= column_count_next;
      row_count <= row_count_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/edd_queue.sv -----
// Two-entry queue that decouples the front end from the diffusion back end.
// Depends on edd_pkg only for house consistency of the project.
`timescale 1ns / 1ps
`default_nettype none
module edd_queue #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      head
);
  import edd_pkg::*;

  logic [W-1:0] slot [2];
  logic wptr, rptr;
  logic [1:0] count, count_next;

  always_comb begin
    full = (count == 2'd2);
    empty = (count == 2'd0);
    head = slot[rptr];
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- src/edd_back.sv -----
// Back end: error line memory, diffusion and threshold stage, and the output register.
// Depends on edd_pkg; consumes requests from edd_queue.
`timescale 1ns / 1ps
`default_nettype none
module edd_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_empty,
  output logic                                pop,
  input  wire logic [edd_pkg::PIXEL_BITS-1:0] q_pixel,
  input  wire logic [AW-1:0]                  q_col,
  input  wire logic [AW-1:0]                  q_rd_addr,
  input  wire edd_pkg::edd_ctl_t              q_ctl,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                pixel_white,
  output logic                                row_end,
  output logic                                frame_end
);
  import edd_pkg::*;

  logic signed [7:0] error_line [MAX_WIDTH];

  logic b1_valid;
  logic [PIXEL_BITS-1:0] b1_pixel;
  logic [AW-1:0] b1_col;
  edd_ctl_t b1_ctl;
  logic signed [7:0] rdata, fwd_data;
  logic fwd;

  logic signed [7:0] left_error, upper_left_error, upper_error, col0_error;
  logic signed [7:0] ur, u_eff, ul_eff, e;
  logic [PIXEL_BITS-1:0] p;
  logic adv_out, b1_fire;

  always_comb begin
    adv_out = !out_valid || !out_stall;
    b1_fire = b1_valid && adv_out;
    pop = !q_empty && (!b1_valid || adv_out);

    ur = (b1_ctl.has_upper && !b1_ctl.last_col) ? (fwd ? fwd_data : rdata) : 8'sd0;
    if (b1_ctl.first_col) begin
      u_eff = b1_ctl.has_upper ? col0_error : 8'sd0;
      ul_eff = 8'sd0;
    end else begin
      u_eff = upper_error;
      ul_eff = upper_left_error;
    end

    p = b1_pixel;
    if (b1_ctl.has_upper) begin
      if (!b1_ctl.first_col) begin
        p = add_clamp(p, weighted(3'd1, ul_eff));
      end
      p = add_clamp(p, weighted(3'd5, u_eff));
      if (!b1_ctl.last_col) begin
        p = add_clamp(p, weighted(3'd3, ur));
      end
    end
    if (!b1_ctl.first_col) begin
      p = add_clamp(p, weighted(3'd7, left_error));
    end

    if (p > WHITE_THRESHOLD) begin
      e = $signed(p - PIXEL_MAX);
    end else begin
      e = $signed(p);
    end
  end

  always_ff @(posedge clk) begin
    if (b1_fire) begin
      error_line[b1_col] <= e;
    end
    if (pop) begin
      rdata <= error_line[q_rd_addr];
      fwd <= b1_fire && (q_rd_addr == b1_col);
      fwd_data <= e;
      b1_pixel <= q_pixel;
      b1_col <= q_col;
      b1_ctl <= q_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      out_valid <= 1'b0;
      left_error <= '0;
      upper_left_error <= '0;
      upper_error <= '0;
    end else begin
      if (pop) begin
        b1_valid <= 1'b1;
      end else if (b1_fire) begin
        b1_valid <= 1'b0;
      end
      if (adv_out) begin
        out_valid <= b1_valid;
      end
      if (b1_fire) begin
        left_error <= e;
        upper_left_error <= u_eff;
        upper_error <= ur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_fire) begin
      pixel_white <= (p > WHITE_THRESHOLD);
      row_end <= b1_ctl.last_col;
      frame_end <= b1_ctl.frame_end;
      if (b1_ctl.first_col) begin
        col0_error <= e;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/error_diffusion_dither.sv -----
// Top level of the Floyd-Steinberg error diffusion dither.
// Depends on edd_pkg, edd_front, edd_queue and edd_back.
//
// Usage: grey pixels enter in raster order on the input channel (in_valid, in_stall,
// pixel_in); a request is taken at a clock edge with in_valid high and in_stall low.
// One result per pixel leaves on the output channel (out_valid, out_stall, pixel_white,
// row_end, frame_end) under the same rule. Frame size is set through the configuration
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data), which is always ready; it must be
// written only while no pixel is in flight, which the block itself does not enforce.
// Throughput is one pixel per cycle while neither channel stalls. An accepted pixel
// passes a queue slot, the error line memory read into the diffusion stage, and the
// diffusion chain, whose left-error feedback sets the rate, into the output register.
// Reset clears the counters, the queue, the pipeline and the diffusion registers, and
// sets min(MAX_WIDTH, 1024) pixels by 1 row; the error line memory is not cleared.
// When the receiver stalls, the output register holds its result, the two-entry queue
// fills, and in_stall rises once the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module error_diffusion_dither #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  pixel_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             pixel_white,
  output logic             row_end,
  output logic             frame_end
);
  import edd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CTLW = $bits(edd_ctl_t);
  localparam int QW = PIXEL_BITS + 2 * AW + CTLW;

  logic push, q_full, q_empty, pop;
  logic [PIXEL_BITS-1:0] f_pixel, q_pixel;
  logic [AW-1:0] f_col, f_rd_addr, q_col, q_rd_addr;
  edd_ctl_t f_ctl, q_ctl;
  logic [QW-1:0] q_head;

  assign cfg_ready = 1'b1;

  edd_front #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .pixel_in(pixel_in),
    .q_full(q_full), .push(push),
    .pixel(f_pixel), .col(f_col), .rd_addr(f_rd_addr), .ctl(f_ctl)
  );

  edd_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_data({f_pixel, f_col, f_rd_addr, f_ctl}), .full(q_full),
    .pop(pop), .empty(q_empty), .head(q_head)
  );

  assign {q_pixel, q_col, q_rd_addr, q_ctl} = q_head;

  edd_back #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .pop(pop),
    .q_pixel(q_pixel), .q_col(q_col), .q_rd_addr(q_rd_addr), .q_ctl(q_ctl),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_white(pixel_white), .row_end(row_end), .frame_end(frame_end)
  );

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!frame_end || row_end))
    else $error("frame_end without row_end");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high right after reset");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> (in_stall && !push))
    else $error("request pushed into a full queue");

endmodule
`default_nettype wire
